// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue unit.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int DQ_DEPTH   = 128;
  localparam int COUNT_W    = 8;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_REVERSE    = 3'd5,
    ACT_SORT       = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    action_t                       action;
    logic signed [DATA_WIDTH-1:0]  value;
  } cmd_t;

  typedef struct packed {
    status_t                       status;
    logic signed [DATA_WIDTH-1:0]  popped_value;
    logic signed [DATA_WIDTH-1:0]  front_value;
    logic signed [DATA_WIDTH-1:0]  back_value;
    logic [COUNT_W-1:0]            element_count;
    logic                          is_empty;
  } rsp_t;

endpackage

// ===== rtl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed words in a ring memory, with in-place reverse and
// insertion sort run by a small sequencer over one compare unit.
// ----------------------------------------------------------------------------
// Usage: one command beat on cmd (action, value) gives exactly one response
// beat on rsp (status, popped word, front/back words, count, empty flag).
// cmd_stall is high while a command is in work; one command at a time.
// Push, pop, clear and unused codes: the command runs through execute, read
// and response-load steps; the response is registered, then idle takes the next one.
// Reverse of n words: floor(n/2) swaps, each a paired read and two writes.
// Sort of n words: each word from the second on is fetched and compared, plus
// one more compare per word shifted; the single write port of the ring memory sets this pace.
// The response sits in an output register, so the next command is taken while
// a response waits; the sequencer holds in its last step only when a new
// response would overwrite one still stalled on rsp.
// Reset empties the deque (head and count to zero) and drops any pending
// response; the memory itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  dq_pkg::cmd_t cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output dq_pkg::rsp_t rsp
);
  import dq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_LOOK,
    S_LOOKW,
    S_REV_RD,
    S_REV_WA,
    S_REV_WB,
    S_SORT_FETCH,
    S_SORT_KEY,
    S_SORT_CMP,
    S_SORT_PLACE
  } state_t;

  state_t                  state;
  action_t                 action_q;
  logic [DATA_WIDTH-1:0]   value_q;
  status_t                 status_q;
  logic                    pop_pending;
  logic [DATA_WIDTH-1:0]   popped;
  logic [AW-1:0]           head;
  logic [CW-1:0]           count;
  logic [AW-1:0]           idx_i;
  logic [AW-1:0]           idx_j;
  logic [AW-1:0]           idx_k;
  logic [DATA_WIDTH-1:0]   word_w;

  logic [DATA_WIDTH-1:0]   mem [DEPTH];
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [DATA_WIDTH-1:0]   wdata;
  logic                    rd_en;
  logic [AW-1:0]           addr_a;
  logic [AW-1:0]           addr_b;
  logic [DATA_WIDTH-1:0]   rd_a;
  logic [DATA_WIDTH-1:0]   rd_b;

  logic                    full;
  logic                    empty;
  logic [AW-1:0]           last_off;
  logic [AW-1:0]           head_dec;
  logic                    gt;
  logic                    sort_last;
  logic                    rsp_load;

  // head plus offset, wrapped into the ring
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_A) sum = sum - DEPTH_A;
    return sum[AW-1:0];
  endfunction

  assign full      = (count == DEPTH_C);
  assign empty     = (count == '0);
  assign last_off  = AW'(count - CW'(1));
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign gt        = $signed(rd_a) > $signed(word_w);
  assign sort_last = ((CW'(idx_i) + CW'(1)) == count);
  assign cmd_stall = (state != S_IDLE);
  assign rsp_load  = (state == S_LOOKW) && (!rsp_valid || !rsp_stall);

  // memory port control
  always_comb begin
    we     = 1'b0;
    waddr  = head;
    wdata  = value_q;
    rd_en  = 1'b0;
    addr_a = head;
    addr_b = head;
    unique case (state)
      S_EXEC: begin
        unique case (action_q)
          ACT_PUSH_FRONT: begin
            we    = !full;
            waddr = head_dec;
          end
          ACT_PUSH_BACK: begin
            we    = !full;
            waddr = ring_pos(head, AW'(count));
          end
          ACT_POP_FRONT: begin
            rd_en = 1'b1;
          end
          ACT_POP_BACK: begin
            rd_en = 1'b1;
            if (!empty) addr_a = ring_pos(head, last_off);
          end
          default: ;
        endcase
      end
      S_LOOK: begin
        rd_en = 1'b1;
        if (!empty) addr_b = ring_pos(head, last_off);
      end
      S_REV_RD: begin
        rd_en  = 1'b1;
        addr_a = ring_pos(head, idx_i);
        addr_b = ring_pos(head, idx_j);
      end
      S_REV_WA: begin
        we    = 1'b1;
        waddr = ring_pos(head, idx_i);
        wdata = rd_b;
      end
      S_REV_WB: begin
        we    = 1'b1;
        waddr = ring_pos(head, idx_j);
        wdata = rd_a;
      end
      S_SORT_FETCH: begin
        rd_en  = 1'b1;
        addr_a = ring_pos(head, idx_i);
      end
      S_SORT_KEY: begin
        rd_en  = 1'b1;
        addr_a = ring_pos(head, idx_i - AW'(1));
      end
      S_SORT_CMP: begin
        we    = 1'b1;
        waddr = ring_pos(head, idx_k);
        if (gt) begin
          // shift the larger word up, fetch the next one down
          wdata = rd_a;
          if (idx_k != AW'(1)) begin
            rd_en  = 1'b1;
            addr_a = ring_pos(head, idx_k - AW'(2));
          end
        end else begin
          wdata = word_w;
        end
      end
      S_SORT_PLACE: begin
        we    = 1'b1;
        wdata = word_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            action_q    <= cmd.action;
            value_q     <= cmd.value;
            status_q    <= ST_OK;
            pop_pending <= 1'b0;
            popped      <= '0;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (action_q == ACT_REVERSE && count > CW'(1)) state <= S_REV_RD;
          else if (action_q == ACT_SORT && count > CW'(1)) state <= S_SORT_FETCH;
          else state <= S_LOOK;
          unique case (action_q)
            ACT_PUSH_FRONT: begin
              if (full) begin
                status_q <= ST_OVERFLOW;
              end else begin
                head  <= head_dec;
                count <= count + CW'(1);
              end
            end
            ACT_PUSH_BACK: begin
              if (full) status_q <= ST_OVERFLOW;
              else count <= count + CW'(1);
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                status_q <= ST_UNDERFLOW;
              end else begin
                pop_pending <= 1'b1;
                head        <= ring_pos(head, AW'(1));
                count       <= count - CW'(1);
              end
            end
            ACT_POP_BACK: begin
              if (empty) begin
                status_q <= ST_UNDERFLOW;
              end else begin
                pop_pending <= 1'b1;
                count       <= count - CW'(1);
              end
            end
            ACT_CLEAR: begin
              head  <= '0;
              count <= '0;
            end
            ACT_REVERSE: begin
              if (count > CW'(1)) begin
                idx_i <= '0;
                idx_j <= last_off;
              end
            end
            ACT_SORT: begin
              if (count > CW'(1)) idx_i <= AW'(1);
            end
            default: ;
          endcase
        end
        S_LOOK: begin
          if (pop_pending) popped <= rd_a;
          state <= S_LOOKW;
        end
        S_LOOKW: begin
          if (rsp_load) begin
            rsp.status        <= status_q;
            rsp.popped_value  <= popped;
            rsp.front_value   <= empty ? '1 : rd_a;
            rsp.back_value    <= empty ? '1 : rd_b;
            rsp.element_count <= COUNT_W'(count);
            rsp.is_empty      <= empty;
            state             <= S_IDLE;
          end
        end
        S_REV_RD: state <= S_REV_WA;
        S_REV_WA: state <= S_REV_WB;
        S_REV_WB: begin
          idx_i <= idx_i + AW'(1);
          idx_j <= idx_j - AW'(1);
          if (({1'b0, idx_i} + (AW+1)'(2)) < {1'b0, idx_j}) state <= S_REV_RD;
          else state <= S_LOOK;
        end
        S_SORT_FETCH: state <= S_SORT_KEY;
        S_SORT_KEY: begin
          word_w <= rd_a;
          idx_k  <= idx_i;
          state  <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (gt) begin
            idx_k <= idx_k - AW'(1);
            if (idx_k == AW'(1)) state <= S_SORT_PLACE;
          end else if (sort_last) begin
            state <= S_LOOK;
          end else begin
            idx_i <= idx_i + AW'(1);
            state <= S_SORT_FETCH;
          end
        end
        S_SORT_PLACE: begin
          if (sort_last) begin
            state <= S_LOOK;
          end else begin
            idx_i <= idx_i + AW'(1);
            state <= S_SORT_FETCH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/dq_checker.sv =====
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks of the double-ended queue unit, bound into the unit module.
// ----------------------------------------------------------------------------
module dq_checker (
  input logic         clk,
  input logic         rst,
  input logic         cmd_valid,
  input logic         cmd_stall,
  input dq_pkg::cmd_t cmd,
  input logic         rsp_valid,
  input logic         rsp_stall,
  input dq_pkg::rsp_t rsp
);
  import dq_pkg::*;

  // one command at a time: busy right after a beat is taken
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command taken while previous one in work");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // empty deque shows no words
  a_empty_view: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |->
      rsp.element_count == '0 && rsp.front_value == '1 && rsp.back_value == '1)
    else $error("empty response shows words");

  // failed steps never pop a word
  a_fail_no_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.popped_value == '0)
    else $error("popped word on failed step");

  // underflow leaves the deque empty
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_UNDERFLOW |-> rsp.is_empty)
    else $error("underflow with words held");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (.*);

// ===== tb/tb_double_ended_queue_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Self-checking bench for the deque unit: a behavioral ring model predicts
// every response beat, random gaps on cmd and stalls on rsp move the timing,
// and directed corners come before fill/drain passes and random walks.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;
  import dq_pkg::*;

  localparam int IDX_W = $clog2(DQ_DEPTH);
  // code 7 has no action and must leave the deque alone
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  // room for responses still owed by the dut
  localparam int EXP_DEPTH = 16;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  double_ended_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the deque
  word_t              shadow_ring [DQ_DEPTH];
  logic [IDX_W-1:0]   shadow_head = '0;
  logic [COUNT_W-1:0] shadow_count = '0;

  rsp_t expected_rsp [EXP_DEPTH];
  int   exp_wr = 0;
  int   exp_rd = 0;
  bit   jitter_on = 1'b0;
  int   stall_left = 0;
  int   err_cnt = 0;
  int   sent_cnt = 0;
  int   checked_cnt = 0;
  int   ovf_cnt = 0;
  int   udf_cnt = 0;
  int   sort_cnt = 0;
  int   rev_cnt = 0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic word_t rand_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $urandom_range(0, 7);
      3: return -$signed($urandom_range(1, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] ring_pos(int off);
    int p;
    p = (int'(shadow_head) + off) % DQ_DEPTH;
    return p[IDX_W-1:0];
  endfunction

  // one step of the shadow deque, returns the response it should give
  function automatic rsp_t deque_step(cmd_t c);
    rsp_t r;
    int i;
    int j;
    int k;
    int n;
    word_t w;
    word_t tmp [DQ_DEPTH];
    r = '0;
    r.status = ST_OK;
    case (c.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (shadow_count >= DQ_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (c.action == ACT_PUSH_FRONT) begin
          shadow_head = ring_pos(DQ_DEPTH - 1);
          shadow_ring[shadow_head] = c.value;
          shadow_count++;
        end else begin
          shadow_ring[ring_pos(shadow_count)] = c.value;
          shadow_count++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (c.action == ACT_POP_FRONT) begin
          r.popped_value = shadow_ring[shadow_head];
          shadow_head = ring_pos(1);
          shadow_count--;
        end else begin
          r.popped_value = shadow_ring[ring_pos(shadow_count - 1)];
          shadow_count--;
        end
      end
      ACT_CLEAR: begin
        shadow_head = '0;
        shadow_count = '0;
      end
      ACT_REVERSE: begin
        rev_cnt++;
        i = 0;
        j = int'(shadow_count) - 1;
        while (i < j) begin
          w = shadow_ring[ring_pos(i)];
          shadow_ring[ring_pos(i)] = shadow_ring[ring_pos(j)];
          shadow_ring[ring_pos(j)] = w;
          i++;
          j--;
        end
      end
      ACT_SORT: begin
        sort_cnt++;
        n = shadow_count;
        for (i = 0; i < n; i++) tmp[i] = shadow_ring[ring_pos(i)];
        for (i = 1; i < n; i++) begin
          w = tmp[i];
          k = i;
          while (k > 0 && tmp[k-1] > w) begin
            tmp[k] = tmp[k-1];
            k--;
          end
          tmp[k] = w;
        end
        for (i = 0; i < n; i++) shadow_ring[ring_pos(i)] = tmp[i];
      end
      default: ;
    endcase
    if (r.status == ST_OVERFLOW) ovf_cnt++;
    if (r.status == ST_UNDERFLOW) udf_cnt++;
    if (shadow_count == 0) begin
      r.front_value = '1;
      r.back_value  = '1;
    end else begin
      r.front_value = shadow_ring[shadow_head];
      r.back_value  = shadow_ring[ring_pos(shadow_count - 1)];
    end
    r.element_count = shadow_count;
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  // drive one command beat and log its expected response once taken
  task automatic send_cmd(input logic [2:0] act, input word_t val);
    cmd_t c;
    int gap;
    c.action = action_t'(act);
    c.value = val;
    gap = jitter_on ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    expected_rsp[exp_wr % EXP_DEPTH] = deque_step(c);
    exp_wr++;
    sent_cnt++;
  endtask

  // stop sending until every response is back
  task automatic wait_idle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // rsp side backpressure
  always @(negedge clk) begin
    if (rst || !jitter_on) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (rsp_stall) begin
      rsp_stall <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else if ($urandom_range(0, 2) == 0) begin
      rsp_stall <= 1'b1;
      stall_left <= idle_len();
    end
  end

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", fname, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (exp_wr == exp_rd) begin
        $error("rsp beat with no command outstanding");
        err_cnt++;
      end else begin
        want = expected_rsp[exp_rd % EXP_DEPTH];
        exp_rd++;
        checked_cnt++;
        check_field("status", want.status, rsp.status);
        check_field("popped_value", want.popped_value, rsp.popped_value);
        check_field("front_value", want.front_value, rsp.front_value);
        check_field("back_value", want.back_value, rsp.back_value);
        check_field("element_count", want.element_count, rsp.element_count);
        check_field("is_empty", want.is_empty, rsp.is_empty);
      end
    end
  end

  // everything that must be harmless on an empty deque
  task automatic test_empty_corners();
    send_cmd(ACT_POP_FRONT, 32'sh1234_5678);
    send_cmd(ACT_POP_BACK, -32'sd1);
    send_cmd(ACT_REVERSE, '0);
    send_cmd(ACT_SORT, '0);
    send_cmd(ACT_UNUSED, 32'sh7fff_ffff);
    send_cmd(ACT_CLEAR, 32'sh8000_0000);
  endtask

  // extreme words, sort by sign, one-word and two-word cases
  task automatic test_word_extremes();
    send_cmd(ACT_PUSH_BACK, 32'sh7fff_ffff);
    send_cmd(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_cmd(ACT_PUSH_BACK, '0);
    send_cmd(ACT_PUSH_FRONT, -32'sd1);
    send_cmd(ACT_PUSH_BACK, 32'sd1);
    send_cmd(ACT_REVERSE, 32'sh5555_5555);
    send_cmd(ACT_SORT, 32'shaaaa_aaaa);
    send_cmd(ACT_POP_FRONT, '0);
    send_cmd(ACT_POP_BACK, '0);
    send_cmd(ACT_POP_BACK, '0);
    send_cmd(ACT_POP_FRONT, '0);
    send_cmd(ACT_REVERSE, '0);
    send_cmd(ACT_SORT, '0);
    send_cmd(ACT_PUSH_FRONT, 32'sd1);
    send_cmd(ACT_SORT, '0);
    send_cmd(ACT_CLEAR, '0);
    send_cmd(ACT_POP_BACK, '0);
  endtask

  // full ring: wrap, overflow and underflow at both ends, whole-ring reverse and sort
  task automatic test_fill_drain();
    int i;
    send_cmd(ACT_CLEAR, rand_word());
    for (i = 0; i < DQ_DEPTH; i++)
      send_cmd($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, rand_word());
    send_cmd(ACT_PUSH_FRONT, rand_word());
    send_cmd(ACT_PUSH_BACK, rand_word());
    send_cmd(ACT_REVERSE, rand_word());
    send_cmd(ACT_SORT, rand_word());
    send_cmd(ACT_UNUSED, rand_word());
    for (i = 0; i < DQ_DEPTH; i++)
      send_cmd($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK, rand_word());
    send_cmd(ACT_POP_FRONT, rand_word());
    send_cmd(ACT_POP_BACK, rand_word());
  endtask

  // segments leaning to push, pop or neither, with the odd reorder or clear
  task automatic test_random_walk(int n_items);
    int done;
    int seg;
    int push_pct;
    int r;
    logic [2:0] act;
    done = 0;
    while (done < n_items) begin
      seg = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (seg) begin
        r = $urandom_range(0, 99);
        if (r < 2) act = ACT_SORT;
        else if (r < 6) act = ACT_REVERSE;
        else if (r < 7) act = ACT_CLEAR;
        else if (r < 8) act = ACT_UNUSED;
        else if ($urandom_range(0, 99) < push_pct)
          act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else
          act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
        send_cmd(act, rand_word());
      end
      done += seg;
      if ($urandom_range(0, 3) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    jitter_on = 1'b0;
    test_empty_corners();
    jitter_on = 1'b1;
    test_word_extremes();
    wait_idle();
    jitter_on = 1'b0;
    test_fill_drain();
    jitter_on = 1'b1;
    test_random_walk(500);
    test_fill_drain();
    test_random_walk(500);
    jitter_on = 1'b0;
    test_random_walk(200);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("sent %0d commands, checked %0d responses", sent_cnt, checked_cnt);
    $display("overflows %0d, underflows %0d, sorts %0d, reverses %0d",
             ovf_cnt, udf_cnt, sort_cnt, rev_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

endmodule
